// ===== hdl/mctb_pkg.sv =====
// ----------------------------------------------------------------------------
// mctb_pkg
// Shared constants for the multi-channel timer bank: sizes, command kinds,
// result codes, timer status codes and the expiry compare request type.
// ----------------------------------------------------------------------------
package mctb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int TIME_W     = 32;
  localparam int TAG_W      = 16;

  // command kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_SETUP   = 3'd1;
  localparam logic [2:0] KIND_START   = 3'd2;
  localparam logic [2:0] KIND_STOP    = 3'd3;
  localparam logic [2:0] KIND_RESTART = 3'd4;

  // result codes
  localparam logic [1:0] EV_OK      = 2'd0;
  localparam logic [1:0] EV_REJECT  = 2'd1;
  localparam logic [1:0] EV_EXPIRED = 2'd2;

  // timer status codes
  localparam logic [1:0] ST_STOPPED = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;

  // operands of the shared expiry compare
  typedef struct packed {
    logic              running;
    logic [TIME_W-1:0] now_count;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] period;
  } cmp_req_t;

endpackage

// ===== hdl/multi_channel_timer_bank.sv =====
// ----------------------------------------------------------------------------
// multi_channel_timer_bank
// Bank of one-shot / periodic timers driven by tick and command beats.
// ----------------------------------------------------------------------------
// Command: busy in S_CMD, where the result is registered; it strobes after.
// Tick: one expiry compare per timer per cycle, busy through the S_SCAN walk
//   and S_FLUSH; each expiry result is held back until the next expiry is
//   found so the final one can carry last; the final result strobes in the
//   cycle right after the busy window.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (rst, synchronous): time count zero, all timers absent and stopped.
// ----------------------------------------------------------------------------
module multi_channel_timer_bank
  import mctb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        kind,
  input  logic [IDX_W-1:0]  timer_index,
  input  logic              load_duration,
  input  logic [TIME_W-1:0] duration_ms,
  input  logic              periodic,
  input  logic [TAG_W-1:0]  tag_in,
  output logic              strobe,
  output logic [1:0]        event_res,
  output logic [IDX_W-1:0]  which_timer,
  output logic [TAG_W-1:0]  tag_out,
  output logic [1:0]        timer_status,
  output logic              last
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMD   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  state_t state;
  state_t state_next;

  logic [TIME_W-1:0] now_count;

  // timer storage
  logic [TIME_W-1:0] start_time  [NUM_TIMERS];
  logic [TIME_W-1:0] period      [NUM_TIMERS];
  logic [TAG_W-1:0]  tag_store   [NUM_TIMERS];
  logic [1:0]        status      [NUM_TIMERS];
  logic              is_periodic [NUM_TIMERS];
  logic              present     [NUM_TIMERS];

  // captured command beat
  logic [2:0]        cmd_kind;
  logic [IDX_W-1:0]  cmd_idx;
  logic              cmd_load;
  logic [TIME_W-1:0] cmd_dur;
  logic              cmd_per;
  logic [TAG_W-1:0]  cmd_tag;

  logic [IDX_W-1:0]  scan_idx;

  // expiry held back until the next one is found so the final one can be flagged
  logic              pend_valid;
  logic [IDX_W-1:0]  pend_idx;
  logic [TAG_W-1:0]  pend_tag;
  logic [1:0]        pend_status;

  // single read port
  logic [IDX_W-1:0]  rd_idx;
  logic [TIME_W-1:0] rd_start;
  logic [TIME_W-1:0] rd_period;
  logic [TAG_W-1:0]  rd_tag;
  logic [1:0]        rd_status;
  logic              rd_per;
  logic              rd_present;

  logic              accept;
  logic              expire;
  cmp_req_t          cmp_req;
  logic [1:0]        scan_status;

  // command decode
  logic              cmd_ok;
  logic              wr_period;
  logic              wr_start;
  logic [1:0]        cmd_status;
  logic [TAG_W-1:0]  cmd_res_tag;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign rd_idx = (state == S_SCAN) ? scan_idx : cmd_idx;

  assign rd_start   = start_time[rd_idx];
  assign rd_period  = period[rd_idx];
  assign rd_tag     = tag_store[rd_idx];
  assign rd_status  = status[rd_idx];
  assign rd_per     = is_periodic[rd_idx];
  assign rd_present = present[rd_idx];

  assign cmp_req.running    = (state == S_SCAN) && (rd_status == ST_RUNNING);
  assign cmp_req.now_count  = now_count;
  assign cmp_req.start_time = rd_start;
  assign cmp_req.period     = rd_period;

  mctb_expiry_unit u_expiry (
    .req    (cmp_req),
    .expire (expire)
  );

  assign scan_status = rd_per ? ST_RUNNING : ST_EXPIRED;

  always_comb begin
    cmd_ok      = 1'b1;
    wr_period   = 1'b0;
    wr_start    = 1'b0;
    cmd_status  = rd_status;
    unique case (cmd_kind)
      KIND_SETUP: begin
        cmd_status = ST_STOPPED;
        wr_period  = 1'b1;
      end
      KIND_START: begin
        cmd_ok     = rd_present && (rd_status != ST_RUNNING);
        wr_period  = cmd_load;
        wr_start   = cmd_ok;
        cmd_status = cmd_ok ? ST_RUNNING : rd_status;
      end
      KIND_STOP: begin
        cmd_status = ST_STOPPED;
      end
      KIND_RESTART: begin
        cmd_ok     = rd_present;
        wr_period  = cmd_load;
        wr_start   = cmd_ok;
        cmd_status = cmd_ok ? ST_RUNNING : ST_STOPPED;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
    if (cmd_kind == KIND_SETUP) begin
      cmd_res_tag = cmd_tag;
    end else if (rd_present) begin
      cmd_res_tag = rd_tag;
    end else begin
      cmd_res_tag = '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (kind == KIND_TICK) ? S_SCAN : S_CMD;
        end
      end
      S_CMD:   state_next = S_IDLE;
      S_SCAN: begin
        if (scan_idx == LAST_IDX) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now_count  <= '0;
      scan_idx   <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        status[i]      <= ST_STOPPED;
        is_periodic[i] <= 1'b0;
        present[i]     <= 1'b0;
      end
    end else begin
      state  <= state_next;
      strobe <= (state == S_CMD) || (state == S_FLUSH && pend_valid) ||
                (state == S_SCAN && expire && pend_valid);
      if (accept && kind == KIND_TICK) begin
        now_count <= now_count + 1'b1;
        scan_idx  <= '0;
      end
      if (state == S_CMD) begin
        status[cmd_idx] <= cmd_status;
        if (cmd_kind == KIND_SETUP) begin
          present[cmd_idx]     <= 1'b1;
          is_periodic[cmd_idx] <= cmd_per;
        end
      end
      if (state == S_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
        if (expire) begin
          pend_valid <= 1'b1;
          if (!rd_per) begin
            status[scan_idx] <= ST_EXPIRED;
          end
        end
      end
      if (state == S_FLUSH) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      cmd_kind <= kind;
      cmd_idx  <= timer_index;
      cmd_load <= load_duration;
      cmd_dur  <= duration_ms;
      cmd_per  <= periodic;
      cmd_tag  <= tag_in;
    end
    if (state == S_CMD) begin
      if (wr_period) begin
        period[cmd_idx] <= cmd_dur;
      end
      if (wr_start) begin
        start_time[cmd_idx] <= now_count;
      end
      if (cmd_kind == KIND_SETUP) begin
        tag_store[cmd_idx] <= cmd_tag;
      end
      event_res    <= cmd_ok ? EV_OK : EV_REJECT;
      which_timer  <= cmd_idx;
      tag_out      <= cmd_res_tag;
      timer_status <= cmd_status;
      last         <= 1'b1;
    end
    if (state == S_SCAN && expire) begin
      if (rd_per) begin
        start_time[scan_idx] <= now_count;
      end
      pend_idx     <= scan_idx;
      pend_tag     <= rd_tag;
      pend_status  <= scan_status;
      event_res    <= EV_EXPIRED;
      which_timer  <= pend_idx;
      tag_out      <= pend_tag;
      timer_status <= pend_status;
      last         <= 1'b0;
    end
    if (state == S_FLUSH) begin
      event_res    <= EV_EXPIRED;
      which_timer  <= pend_idx;
      tag_out      <= pend_tag;
      timer_status <= pend_status;
      last         <= 1'b1;
    end
  end

  // a result only follows a command step, a scan step or the flush
  a_strobe_source: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($past(state) == S_CMD || $past(state) == S_SCAN ||
                $past(state) == S_FLUSH))
    else $error("result strobe without a producing step");

  // a command beat is answered with a final result once its S_CMD step is done
  a_cmd_path: assert property (@(posedge clk) disable iff (rst)
    (accept && kind != KIND_TICK) |=> ##1 (strobe && last))
    else $error("command beat not answered");

  // scan walks the timers one per cycle
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_idx != LAST_IDX) |=>
      (state == S_SCAN && scan_idx == $past(scan_idx) + 1'b1))
    else $error("scan index skipped");

  // the flagged final result is never followed by another in the next cycle
  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("result after final result of a beat");

  // nothing is left pending once the bank is idle
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("held expiry left behind");

endmodule

// ===== hdl/mctb_expiry_unit.sv =====
// ----------------------------------------------------------------------------
// mctb_expiry_unit
// Shared compare: a running timer expires when the wrap-safe elapsed time
// since its start is strictly greater than its period.
// ----------------------------------------------------------------------------
module mctb_expiry_unit
  import mctb_pkg::*;
(
  input  cmp_req_t req,
  output logic     expire
);

  logic [TIME_W-1:0] elapsed;

  // modulo 2^32 difference keeps the compare correct across counter wrap
  assign elapsed = req.now_count - req.start_time;
  assign expire  = req.running && (elapsed > req.period);

endmodule

// ===== tb/sv/tb_multi_channel_timer_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_timer_bank
// Self-checking bench for the timer bank. A queue of command and tick beats
// (a directed opening, then weighted random traffic with all-timer bursts)
// feeds a clocked driver with random gaps. An in-bench timer bank model
// predicts every result beat, and a clocked monitor checks each strobed
// result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_multi_channel_timer_bank;
  import mctb_pkg::*;

  localparam int RANDOM_BEATS = 356;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    logic [2:0]        kind;
    logic [IDX_W-1:0]  idx;
    logic              load;
    logic [TIME_W-1:0] dur;
    logic              per;
    logic [TAG_W-1:0]  tag;
  } cmd_beat_t;

  typedef struct {
    logic [1:0]       ev;
    logic [IDX_W-1:0] which;
    logic [TAG_W-1:0] tag;
    logic [1:0]       st;
    logic             fin;
  } timer_event_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        kind = KIND_TICK;
  logic [IDX_W-1:0]  timer_index = '0;
  logic              load_duration = 1'b0;
  logic [TIME_W-1:0] duration_ms = '0;
  logic              periodic = 1'b0;
  logic [TAG_W-1:0]  tag_in = '0;
  logic              strobe;
  logic [1:0]        event_res;
  logic [IDX_W-1:0]  which_timer;
  logic [TAG_W-1:0]  tag_out;
  logic [1:0]        timer_status;
  logic              last;

  multi_channel_timer_bank dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .timer_index(timer_index), .load_duration(load_duration),
    .duration_ms(duration_ms), .periodic(periodic), .tag_in(tag_in),
    .strobe(strobe), .event_res(event_res), .which_timer(which_timer),
    .tag_out(tag_out), .timer_status(timer_status), .last(last)
  );

  // timer bank model state
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] t_start  [NUM_TIMERS];
  logic [TIME_W-1:0] t_period [NUM_TIMERS];
  logic [1:0]        t_status [NUM_TIMERS];
  logic              t_per    [NUM_TIMERS];
  logic [TAG_W-1:0]  t_tag    [NUM_TIMERS];
  logic              t_present[NUM_TIMERS];

  cmd_beat_t    cmd_backlog[$];
  timer_event_t expected_events[$];
  cmd_beat_t    cur_cmd;

  int          n_errors = 0;
  int          n_accepted = 0;
  int          n_ticks = 0;
  int          n_results = 0;
  int          n_expiries = 0;
  int          cycles = 0;
  int unsigned gap_left = 0;
  bit          steady = 1'b0;

  initial begin
    now_ms = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      t_start[i]   = '0;
      t_period[i]  = '0;
      t_status[i]  = ST_STOPPED;
      t_per[i]     = 1'b0;
      t_tag[i]     = '0;
      t_present[i] = 1'b0;
    end
  end

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic note_mismatch(string what);
    if (n_errors < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $time, what);
    n_errors++;
  endtask

  function automatic timer_event_t make_event(logic [1:0] ev, int i, logic fin);
    timer_event_t e;
    e.ev    = ev;
    e.which = IDX_W'(i);
    e.tag   = t_present[i] ? t_tag[i] : '0;
    e.st    = t_status[i];
    e.fin   = fin;
    return e;
  endfunction

  // advance the bank by one accepted beat and queue what it should report
  task automatic predict_timer_events(cmd_beat_t c);
    timer_event_t      hits[$];
    logic [TIME_W-1:0] elapsed;
    logic              ok;
    int                i;
    i = int'(c.idx);
    ok = 1'b1;
    if (c.kind == KIND_TICK) begin
      now_ms = now_ms + 1;
      for (int k = 0; k < NUM_TIMERS; k++) begin
        elapsed = now_ms - t_start[k];
        if (t_status[k] == ST_RUNNING && elapsed > t_period[k]) begin
          if (t_per[k])
            t_start[k] = now_ms;
          else
            t_status[k] = ST_EXPIRED;
          hits.insert(hits.size(), make_event(EV_EXPIRED, k, 1'b0));
        end
      end
      if (hits.size() > 0)
        hits[hits.size()-1].fin = 1'b1;
      foreach (hits[k])
        expected_events.insert(expected_events.size(), hits[k]);
    end else begin
      case (c.kind)
        KIND_SETUP: begin
          t_present[i] = 1'b1;
          t_period[i]  = c.dur;
          t_per[i]     = c.per;
          t_tag[i]     = c.tag;
          t_status[i]  = ST_STOPPED;
        end
        KIND_START: begin
          if (c.load)
            t_period[i] = c.dur;
          ok = t_present[i] && t_status[i] != ST_RUNNING;
        end
        KIND_STOP: t_status[i] = ST_STOPPED;
        KIND_RESTART: begin
          if (c.load)
            t_period[i] = c.dur;
          t_status[i] = ST_STOPPED;
          ok = t_present[i];
        end
        default: ok = 1'b0;
      endcase
      if (ok && (c.kind == KIND_START || c.kind == KIND_RESTART)) begin
        t_status[i] = ST_RUNNING;
        t_start[i]  = now_ms;
      end
      expected_events.insert(expected_events.size(),
                             make_event(ok ? EV_OK : EV_REJECT, i, 1'b1));
    end
  endtask

  task automatic queue_cmd(logic [2:0] k, int i, logic ld, logic [TIME_W-1:0] d,
                           logic p, logic [TAG_W-1:0] t);
    cmd_beat_t c;
    c.kind = k;
    c.idx  = IDX_W'(i);
    c.load = ld;
    c.dur  = d;
    c.per  = p;
    c.tag  = t;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  // tick with junk in the fields the bank ignores
  task automatic queue_tick();
    queue_cmd(KIND_TICK, $urandom_range(0, NUM_TIMERS-1), 1'($urandom), $urandom(),
              1'($urandom), 16'($urandom));
  endtask

  // mostly short periods so timers expire often, now and then huge ones
  function automatic logic [TIME_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 6) return TIME_W'($urandom_range(0, 6));
    if (r == 7) return TIME_W'($urandom_range(0, 40));
    if (r == 8) return $urandom();
    return '1;
  endfunction

  task automatic queue_random_cmd();
    int r;
    int i;
    r = $urandom_range(0, 99);
    i = $urandom_range(0, NUM_TIMERS-1);
    if (r < 45)
      queue_tick();
    else if (r < 60)
      queue_cmd(KIND_SETUP, i, 1'($urandom), pick_duration(), 1'($urandom), 16'($urandom));
    else if (r < 76)
      queue_cmd(KIND_START, i, 1'($urandom), pick_duration(), 1'($urandom), 16'($urandom));
    else if (r < 84)
      queue_cmd(KIND_STOP, i, 1'($urandom), $urandom(), 1'($urandom), 16'($urandom));
    else if (r < 95)
      queue_cmd(KIND_RESTART, i, 1'($urandom), pick_duration(), 1'($urandom),
                16'($urandom));
    else
      queue_cmd(KIND_RESTART + 3'($urandom_range(1, 3)), i, 1'($urandom), $urandom(),
                1'($urandom), 16'($urandom));
  endtask

  // every timer at period zero, so one tick reports all of them
  task automatic queue_full_burst();
    for (int i = 0; i < NUM_TIMERS; i++)
      queue_cmd(KIND_SETUP, i, 1'b0, '0, 1'($urandom), 16'($urandom));
    for (int i = 0; i < NUM_TIMERS; i++)
      queue_cmd(KIND_START, i, 1'b0, $urandom(), 1'($urandom), 16'($urandom));
    queue_tick();
    queue_tick();
  endtask

  // driver: start may only change once the current beat is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        predict_timer_events(cur_cmd);
        n_accepted++;
        if (cur_cmd.kind == KIND_TICK)
          n_ticks++;
        if (n_accepted % 60 == 0)
          steady = ~steady;
        gap_left = steady ? 0 : $urandom_range(0, 3);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          cur_cmd = cmd_backlog.pop_front();
          start <= 1'b1;
          kind <= cur_cmd.kind;
          timer_index <= cur_cmd.idx;
          load_duration <= cur_cmd.load;
          duration_ms <= cur_cmd.dur;
          periodic <= cur_cmd.per;
          tag_in <= cur_cmd.tag;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: one result beat per strobe, no back-pressure possible
  always @(posedge clk) begin
    timer_event_t e;
    if (!rst && strobe === 1'b1) begin
      n_results++;
      if (event_res === EV_EXPIRED)
        n_expiries++;
      if (expected_events.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat ev=%0d timer=%0d",
                                event_res, which_timer));
      end else begin
        e = expected_events.pop_front();
        if (event_res !== e.ev)
          note_mismatch($sformatf("event_res %0d, want %0d", event_res, e.ev));
        if (which_timer !== e.which)
          note_mismatch($sformatf("which_timer %0d, want %0d", which_timer, e.which));
        if (tag_out !== e.tag)
          note_mismatch($sformatf("tag_out %h, want %h (timer %0d)", tag_out, e.tag,
                                  e.which));
        if (timer_status !== e.st)
          note_mismatch($sformatf("timer_status %0d, want %0d (timer %0d)",
                                  timer_status, e.st, e.which));
        if (last !== e.fin)
          note_mismatch($sformatf("last %b, want %b (timer %0d)", last, e.fin, e.which));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_events.size());
      $display("multi_channel_timer_bank verification failed");
      $finish;
    end
  end

  initial begin
    int n_random;
    // directed opening: rejects on absent timers, extremes, expiry kinds
    queue_cmd(KIND_RESTART + 3'd1, 3, 1'b1, '1, 1'b1, 16'hFFFF);
    queue_cmd(KIND_START, 2, 1'b1, 32'd5, 1'b0, 16'h0);
    queue_cmd(KIND_STOP, 2, 1'b0, '0, 1'b0, 16'h0);
    queue_cmd(KIND_RESTART, 2, 1'b1, 32'd3, 1'b1, 16'h1234);
    queue_cmd(KIND_SETUP, 0, 1'b0, '0, 1'b0, 16'hFFFF);
    queue_cmd(KIND_SETUP, 1, 1'b1, 32'd2, 1'b1, 16'h0000);
    queue_cmd(KIND_SETUP, NUM_TIMERS-1, 1'b0, '1, 1'b1, 16'hA5A5);
    queue_cmd(KIND_START, 0, 1'b0, '1, 1'b1, 16'h5A5A);
    queue_cmd(KIND_START, 0, 1'b0, '0, 1'b0, 16'h0);
    queue_cmd(KIND_START, 1, 1'b0, '0, 1'b0, 16'h0);
    queue_cmd(KIND_RESTART, NUM_TIMERS-1, 1'b1, '1, 1'b0, 16'h0);
    repeat (4) queue_tick();
    queue_cmd(KIND_RESTART + 3'd3, 0, 1'b0, '0, 1'b0, 16'h0);
    queue_cmd(KIND_START, 0, 1'b1, 32'd1, 1'b0, 16'h0);
    queue_cmd(KIND_RESTART + 3'd2, 1, 1'b1, '1, 1'b1, 16'hFFFF);
    queue_cmd(KIND_STOP, 1, 1'b0, '0, 1'b0, 16'h0);
    queue_cmd(KIND_RESTART, 1, 1'b0, '0, 1'b0, 16'h0);
    repeat (2) queue_tick();
    queue_cmd(KIND_SETUP, 0, 1'b0, 32'd4, 1'b0, 16'h8001);
    queue_tick();

    n_random = 0;
    while (n_random < RANDOM_BEATS) begin
      if (n_random == 100 || n_random == 250) begin
        queue_full_burst();
        n_random += 2 * NUM_TIMERS + 2;
      end else begin
        queue_random_cmd();
        n_random++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() > 0 || start)
      @(posedge clk);
    while (expected_events.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d beats (%0d ticks, final time count %0d)", n_accepted,
             n_ticks, now_ms);
    $display("checked %0d result beats, %0d of them expiries, %0d mismatches",
             n_results, n_expiries, n_errors);
    if (n_errors == 0 && expected_events.size() == 0) begin
      $display("multi_channel_timer_bank verification clean");
    end else begin
      $display("multi_channel_timer_bank verification failed");
    end
    $finish;
  end

endmodule

// ===== multi_channel_timer_bank.f =====
hdl/mctb_pkg.sv
hdl/mctb_expiry_unit.sv
hdl/multi_channel_timer_bank.sv
tb/sv/tb_multi_channel_timer_bank.sv
